[rtl/jvss_pkg.sv]
// Shared types and constants for the JSON value skip scanner.
// Depends on nothing; used by json_value_skip_scanner_core.
package jvss_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CHAR_W      = 8;
    localparam int DEPTH_W     = 6;

    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [IDX_W-1:0]   index_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [DEPTH_W-1:0] depth_t;

    typedef enum logic [1:0] {
        MARK_SQUOTE  = 2'd0,
        MARK_DQUOTE  = 2'd1,
        MARK_BRACKET = 2'd2,
        MARK_BRACE   = 2'd3
    } mark_t;

    typedef enum logic [1:0] {
        ST_CONT = 2'd0,
        ST_OK   = 2'd1,
        ST_ERR  = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    localparam char_t CH_NUL      = 8'h00;
    localparam char_t CH_SQUOTE   = 8'h27;
    localparam char_t CH_DQUOTE   = 8'h22;
    localparam char_t CH_LBRACKET = 8'h5B;
    localparam char_t CH_RBRACKET = 8'h5D;
    localparam char_t CH_LBRACE   = 8'h7B;
    localparam char_t CH_RBRACE   = 8'h7D;
    localparam char_t CH_COMMA    = 8'h2C;

endpackage

[rtl/json_value_skip_scanner_core.sv]
// JSON value skip scanner: bracket matching over a stack of open marks.
// Depends on jvss_pkg (types, mark and status codes, character constants).
//
// Usage:
//   Input channel (in_valid / in_ready / text_char) carries one text byte per
//   transfer. Output channel (out_valid / out_ready / scan_status /
//   nesting_depth) carries one result per input byte, in order.
//   Each byte is decoded against the stack top and stack count in the cycle
//   it is transferred; the stack and count update at that edge and the
//   result lands in the output register, or in the skid register when the
//   output is stalled. Throughput is one byte per cycle while in_ready is
//   high; the only path that sets it is the top-of-stack read and count
//   update.
//   A skid register sits behind the output register: when the receiver
//   stalls, one more result is held there and in_ready then drops until the
//   output register drains. in_ready depends only on local state.
//   Reset clears the stack count, the scan flag and both valid flags; the
//   mark stack itself is not cleared, since only entries pushed in the
//   current scan are ever read.
//   scan_status: 0 continue, 1 success, 2 error, 3 stack overflow. Any
//   nonzero status ends the scan; the next byte starts a fresh one.
module json_value_skip_scanner_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  jvss_pkg::char_t     text_char,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          scan_status,
    output jvss_pkg::depth_t    nesting_depth
);

    // Mark stack (payload, no reset) and scan control state.
    jvss_pkg::mark_t  stack_reg [jvss_pkg::STACK_DEPTH];
    jvss_pkg::count_t count_reg, count_next;
    logic             scan_reg, scan_next;

    // Output register and skid stage.
    logic              out_valid_reg, out_valid_next;
    jvss_pkg::status_t out_status_reg, out_status_next;
    jvss_pkg::depth_t  out_depth_reg, out_depth_next;
    logic              skid_valid_reg, skid_valid_next;
    jvss_pkg::status_t skid_status_reg, skid_status_next;
    jvss_pkg::depth_t  skid_depth_reg, skid_depth_next;

    // Per-byte decode results.
    logic              in_fire;
    logic              out_fire;
    logic              stack_empty;
    logic              stack_full;
    jvss_pkg::mark_t   top_mark;
    jvss_pkg::count_t  count_dec;
    jvss_pkg::count_t  count_res;
    jvss_pkg::status_t res_status;
    jvss_pkg::depth_t  res_depth;
    logic              do_push;
    jvss_pkg::mark_t   push_mark;

    assign in_ready    = !skid_valid_reg;
    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid_reg && out_ready;
    assign out_valid   = out_valid_reg;
    assign scan_status = out_status_reg;
    assign nesting_depth = out_depth_reg;

    // Stack count is held at zero whenever no scan is in progress, so it
    // serves directly as the count at the start of a new scan.
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == jvss_pkg::count_t'(jvss_pkg::STACK_DEPTH));
    assign count_dec   = count_reg - jvss_pkg::count_t'(1);
    assign top_mark    = stack_reg[count_dec[jvss_pkg::IDX_W-1:0]];

    // Decode one byte against the stack top.
    always_comb
    begin
        res_status = jvss_pkg::ST_CONT;
        count_res  = count_reg;
        do_push    = 1'b0;
        push_mark  = jvss_pkg::MARK_SQUOTE;

        if (!scan_reg && text_char == jvss_pkg::CH_NUL) begin
            // Zero byte as the first byte of a scan: error, no scan started.
            res_status = jvss_pkg::ST_ERR;
        end
        else begin
            unique case (text_char) inside
                jvss_pkg::CH_SQUOTE, jvss_pkg::CH_DQUOTE:
                begin
                    push_mark = (text_char == jvss_pkg::CH_DQUOTE) ?
                                jvss_pkg::MARK_DQUOTE : jvss_pkg::MARK_SQUOTE;
                    if (!stack_empty && top_mark == push_mark) begin
                        count_res = count_dec;
                    end
                    else if (stack_full) begin
                        res_status = jvss_pkg::ST_OVF;
                    end
                    else begin
                        do_push = 1'b1;
                    end
                end
                jvss_pkg::CH_RBRACKET:
                begin
                    if (!stack_empty && top_mark == jvss_pkg::MARK_BRACKET) begin
                        count_res = count_dec;
                    end
                    else begin
                        res_status = jvss_pkg::ST_ERR;
                    end
                end
                jvss_pkg::CH_RBRACE:
                begin
                    if (!stack_empty && top_mark == jvss_pkg::MARK_BRACE) begin
                        count_res = count_dec;
                    end
                    else begin
                        res_status = stack_empty ? jvss_pkg::ST_OK : jvss_pkg::ST_ERR;
                    end
                end
                jvss_pkg::CH_LBRACKET, jvss_pkg::CH_LBRACE:
                begin
                    push_mark = (text_char == jvss_pkg::CH_LBRACKET) ?
                                jvss_pkg::MARK_BRACKET : jvss_pkg::MARK_BRACE;
                    if (stack_full) begin
                        res_status = jvss_pkg::ST_OVF;
                    end
                    else begin
                        do_push = 1'b1;
                    end
                end
                jvss_pkg::CH_COMMA:
                begin
                    if (stack_empty) begin
                        res_status = jvss_pkg::ST_OK;
                    end
                end
                jvss_pkg::CH_NUL:
                begin
                    res_status = stack_empty ? jvss_pkg::ST_OK : jvss_pkg::ST_ERR;
                end
                default:
                begin
                    // Any other byte leaves the stack alone.
                end
            endcase
            if (do_push) begin
                count_res = count_reg + jvss_pkg::count_t'(1);
            end
        end

        res_depth = jvss_pkg::depth_t'(count_res);
    end

    // Next state for scan control and the output/skid pair.
    always_comb
    begin
        count_next       = count_reg;
        scan_next        = scan_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_depth_next   = out_depth_reg;
        skid_valid_next  = skid_valid_reg;
        skid_status_next = skid_status_reg;
        skid_depth_next  = skid_depth_reg;

        if (in_fire) begin
            // Any stop empties the stack and ends the scan.
            if (res_status != jvss_pkg::ST_CONT) begin
                count_next = '0;
                scan_next  = 1'b0;
            end
            else begin
                count_next = count_res;
                scan_next  = 1'b1;
            end
        end

        // Drain: advance the skid into the output register, or drop the
        // output valid when a transfer leaves nothing behind.
        if (out_fire) begin
            out_valid_next = skid_valid_reg;
            out_status_next = skid_status_reg;
            out_depth_next  = skid_depth_reg;
            skid_valid_next = 1'b0;
        end

        // Fill: a new result goes to the output register when it is free
        // (or being emptied), otherwise hold it in the skid stage.
        if (in_fire) begin
            if (!out_valid_reg || out_ready) begin
                out_valid_next  = 1'b1;
                out_status_next = res_status;
                out_depth_next  = res_depth;
            end
            else begin
                skid_valid_next  = 1'b1;
                skid_status_next = res_status;
                skid_depth_next  = res_depth;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg      <= '0;
            scan_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        out_depth_reg   <= out_depth_next;
        skid_status_reg <= skid_status_next;
        skid_depth_reg  <= skid_depth_next;
    end

    // Push writes the slot just above the current top.
    always_ff @(posedge clk)
    begin
        if (in_fire && do_push) begin
            stack_reg[count_reg[jvss_pkg::IDX_W-1:0]] <= push_mark;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= jvss_pkg::count_t'(jvss_pkg::STACK_DEPTH))
        else $error("stack count above stack depth");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !scan_reg |-> count_reg == '0)
        else $error("stack not empty outside a scan");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res_status != jvss_pkg::ST_CONT |=> count_reg == '0 && !scan_reg)
        else $error("stop did not end the scan");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && do_push |-> !stack_full)
        else $error("push on a full stack");
`endif

endmodule

[dv/json_value_skip_scanner_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for json_value_skip_scanner_core: streams text bytes, predicts
// the scan status and nesting depth of each one and checks them. Depends on jvss_pkg.
module json_value_skip_scanner_core_tb;

    typedef struct packed {
        jvss_pkg::status_t status;
        jvss_pkg::depth_t  depth;
    } scan_result_t;

    localparam int TEXT_BYTES  = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;
    localparam int IDLE_PCT    = 19;
    localparam int QUIET_FROM  = 300;
    localparam int QUIET_TO    = 700;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    jvss_pkg::char_t  text_char = jvss_pkg::CH_NUL;
    logic   out_valid;
    logic   out_ready = 1'b0;
    logic [1:0] scan_status;
    jvss_pkg::depth_t nesting_depth;

    // Bytes waiting to be driven and results waiting to be seen.
    jvss_pkg::char_t pending_chars[$];
    scan_result_t    expected_results[$];
    int              mismatch_count = 0;
    int              cycle_count = 0;

    // Scanner shadow state: mark stack, its fill level and the open-scan flag.
    jvss_pkg::mark_t shadow_marks [jvss_pkg::STACK_DEPTH];
    int    shadow_count = 0;
    bit    shadow_scanning = 1'b0;

    always #2 clk = ~clk;

    json_value_skip_scanner_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_char     (text_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .scan_status   (scan_status),
        .nesting_depth (nesting_depth)
    );

    // Idling is switched off inside the quiet window so that a long run of
    // back-to-back transfers with no stalls also gets exercised.
    function automatic bit roll_idle();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Append one byte to the drive queue.
    function automatic void queue_char(jvss_pkg::char_t ch);
        pending_chars.insert(pending_chars.size(), ch);
    endfunction

    function automatic bit top_matches(jvss_pkg::mark_t m);
        return shadow_count > 0 && shadow_marks[shadow_count-1] == m;
    endfunction

    // Push a mark; a full stack turns the push into an overflow stop.
    function automatic jvss_pkg::status_t open_mark(jvss_pkg::mark_t m);
        if (shadow_count == jvss_pkg::STACK_DEPTH)
            return jvss_pkg::ST_OVF;
        shadow_marks[shadow_count] = m;
        shadow_count++;
        return jvss_pkg::ST_CONT;
    endfunction

    // Advance the shadow scanner by one byte and queue the result it produces.
    function automatic void advance_scan(jvss_pkg::char_t ch);
        scan_result_t    r;
        jvss_pkg::mark_t m;
        r.status = jvss_pkg::ST_CONT;
        r.depth  = '0;
        if (!shadow_scanning) begin
            shadow_count = 0;
            // A zero byte cannot open a scan: report an error and stay idle.
            if (ch == jvss_pkg::CH_NUL) begin
                r.status = jvss_pkg::ST_ERR;
                expected_results.insert(expected_results.size(), r);
                return;
            end
            shadow_scanning = 1'b1;
        end
        case (ch) inside
            jvss_pkg::CH_SQUOTE, jvss_pkg::CH_DQUOTE: begin
                m = (ch == jvss_pkg::CH_DQUOTE) ? jvss_pkg::MARK_DQUOTE
                                                : jvss_pkg::MARK_SQUOTE;
                if (top_matches(m))
                    shadow_count--;
                else
                    r.status = open_mark(m);
            end
            jvss_pkg::CH_RBRACKET: begin
                if (top_matches(jvss_pkg::MARK_BRACKET))
                    shadow_count--;
                else
                    r.status = jvss_pkg::ST_ERR;
            end
            jvss_pkg::CH_RBRACE: begin
                if (top_matches(jvss_pkg::MARK_BRACE))
                    shadow_count--;
                else
                    r.status = (shadow_count == 0) ? jvss_pkg::ST_OK : jvss_pkg::ST_ERR;
            end
            jvss_pkg::CH_LBRACKET: r.status = open_mark(jvss_pkg::MARK_BRACKET);
            jvss_pkg::CH_LBRACE:   r.status = open_mark(jvss_pkg::MARK_BRACE);
            jvss_pkg::CH_COMMA:    if (shadow_count == 0) r.status = jvss_pkg::ST_OK;
            jvss_pkg::CH_NUL:
                r.status = (shadow_count == 0) ? jvss_pkg::ST_OK : jvss_pkg::ST_ERR;
            default: ;
        endcase
        // Depth is taken before a stop empties the stack.
        r.depth = jvss_pkg::depth_t'(shadow_count);
        if (r.status != jvss_pkg::ST_CONT) begin
            shadow_count    = 0;
            shadow_scanning = 1'b0;
        end
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic bit is_structural(jvss_pkg::char_t ch);
        return ch == jvss_pkg::CH_NUL || ch == jvss_pkg::CH_SQUOTE
            || ch == jvss_pkg::CH_DQUOTE || ch == jvss_pkg::CH_COMMA
            || ch == jvss_pkg::CH_LBRACKET || ch == jvss_pkg::CH_RBRACKET
            || ch == jvss_pkg::CH_LBRACE || ch == jvss_pkg::CH_RBRACE;
    endfunction

    // Any byte that leaves the stack alone, high-bit bytes included.
    function automatic jvss_pkg::char_t plain_char();
        jvss_pkg::char_t ch;
        do
            ch = jvss_pkg::char_t'($urandom_range(1, 255));
        while (is_structural(ch));
        return ch;
    endfunction

    function automatic jvss_pkg::char_t opener_of(jvss_pkg::mark_t m);
        case (m)
            jvss_pkg::MARK_SQUOTE:  return jvss_pkg::CH_SQUOTE;
            jvss_pkg::MARK_DQUOTE:  return jvss_pkg::CH_DQUOTE;
            jvss_pkg::MARK_BRACKET: return jvss_pkg::CH_LBRACKET;
            default:                return jvss_pkg::CH_LBRACE;
        endcase
    endfunction

    function automatic jvss_pkg::char_t closer_of(jvss_pkg::mark_t m);
        case (m)
            jvss_pkg::MARK_SQUOTE:  return jvss_pkg::CH_SQUOTE;
            jvss_pkg::MARK_DQUOTE:  return jvss_pkg::CH_DQUOTE;
            jvss_pkg::MARK_BRACKET: return jvss_pkg::CH_RBRACKET;
            default:                return jvss_pkg::CH_RBRACE;
        endcase
    endfunction

    // Queue one value: a nest of opens with filler, then its closes (all or,
    // for a broken value, some of them), then a terminator or none. A few values are
    // pure noise of arbitrary bytes instead.
    task automatic queue_value();
        jvss_pkg::mark_t opened[$];
        jvss_pkg::mark_t m;
        int    kind;
        int    nest;
        int    closes;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 8))
                queue_char(jvss_pkg::char_t'($urandom_range(0, 255)));
            return;
        end
        // Mostly shallow nests; now and then one that nears, reaches or passes full.
        nest = (kind < 18) ? $urandom_range(jvss_pkg::STACK_DEPTH - 3,
                                            jvss_pkg::STACK_DEPTH + 1)
                           : $urandom_range(0, 5);
        repeat (nest) begin
            if ($urandom_range(0, 3) == 0)
                queue_char(plain_char());
            m = jvss_pkg::mark_t'($urandom_range(0, 3));
            // Hold off a repeated quote: it would close instead of open.
            if ((m == jvss_pkg::MARK_SQUOTE || m == jvss_pkg::MARK_DQUOTE)
                    && opened.size() > 0 && opened[$] == m)
                m = jvss_pkg::MARK_BRACKET;
            opened.insert(opened.size(), m);
            queue_char(opener_of(m));
        end
        closes = (kind < 30) ? $urandom_range(0, opened.size()) : opened.size();
        repeat (closes) begin
            if ($urandom_range(0, 3) == 0)
                queue_char(plain_char());
            queue_char(closer_of(opened.pop_back()));
        end
        case ($urandom_range(0, 4))
            0: queue_char(jvss_pkg::CH_COMMA);
            1: queue_char(jvss_pkg::CH_NUL);
            2: queue_char(jvss_pkg::CH_RBRACE);
            3: queue_char(jvss_pkg::CH_RBRACKET);
            default: ;
        endcase
    endtask

    // Driver: offer the next byte once the current one has transferred.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid)
                advance_scan(text_char);
            if (pending_chars.size() == 0 || roll_idle()) begin
                in_valid <= 1'b0;
            end else begin
                in_valid  <= 1'b1;
                text_char <= pending_chars.pop_front();
            end
        end
    end

    // Monitor: stall the output at random and check every transfer in order.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: scan_status %0d nesting_depth %0d",
                           scan_status, nesting_depth);
                    mismatch_count++;
                end else begin
                    if (scan_status !== expected_results[0].status) begin
                        $error("scan_status: expected %0d, got %0d",
                               expected_results[0].status, scan_status);
                        mismatch_count++;
                    end
                    if (nesting_depth !== expected_results[0].depth) begin
                        $error("nesting_depth: expected %0d, got %0d",
                               expected_results[0].depth, nesting_depth);
                        mismatch_count++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            out_ready <= !roll_idle();
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL json_value_skip_scanner_core");
            $finish;
        end
    end

    initial begin
        // Zero byte as the first byte of a scan.
        queue_char(jvss_pkg::CH_NUL);
        // Close bracket against a quote on top: error at depth two.
        queue_char(jvss_pkg::CH_LBRACE);
        queue_char(8'h61);
        queue_char(jvss_pkg::CH_DQUOTE);
        queue_char(jvss_pkg::CH_RBRACKET);
        // Comma and close brace on an empty stack succeed, close bracket fails.
        queue_char(jvss_pkg::CH_COMMA);
        queue_char(jvss_pkg::CH_RBRACE);
        queue_char(jvss_pkg::CH_RBRACKET);
        // Quotes nested in a bracket, extreme plain bytes, clean end of text.
        queue_char(jvss_pkg::CH_LBRACKET);
        queue_char(jvss_pkg::CH_SQUOTE);
        queue_char(jvss_pkg::CH_DQUOTE);
        queue_char(8'hFF);
        queue_char(jvss_pkg::CH_DQUOTE);
        queue_char(jvss_pkg::CH_SQUOTE);
        queue_char(8'h01);
        queue_char(jvss_pkg::CH_RBRACKET);
        queue_char(8'h80);
        queue_char(jvss_pkg::CH_NUL);
        // Close brace over an open bracket on a nonempty stack.
        queue_char(jvss_pkg::CH_LBRACE);
        queue_char(jvss_pkg::CH_LBRACKET);
        queue_char(jvss_pkg::CH_RBRACE);
        // Comma inside a value continues; zero byte with marks open fails.
        queue_char(jvss_pkg::CH_LBRACKET);
        queue_char(jvss_pkg::CH_COMMA);
        queue_char(jvss_pkg::CH_NUL);
        // Fill the stack to the brim, then push once more for an overflow.
        repeat (jvss_pkg::STACK_DEPTH + 1)
            queue_char(jvss_pkg::CH_LBRACE);
        while (pending_chars.size() < TEXT_BYTES)
            queue_value();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge so that the driver's updates have settled.
        while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS json_value_skip_scanner_core");
        else
            $display("FAIL json_value_skip_scanner_core");
        $finish;
    end

endmodule

[sim.f]
rtl/jvss_pkg.sv
rtl/json_value_skip_scanner_core.sv
dv/json_value_skip_scanner_core_tb.sv
